>>> src/ckrm_pkg.sv
package ckrm_pkg;

  // Surface format codes
  localparam logic [4:0] FMT_X4R4G4B4 = 5'd0;
  localparam logic [4:0] FMT_A4R4G4B4 = 5'd1;
  localparam logic [4:0] FMT_X1R5G5B5 = 5'd2;
  localparam logic [4:0] FMT_A1R5G5B5 = 5'd3;
  localparam logic [4:0] FMT_R5G6B5   = 5'd4;
  localparam logic [4:0] FMT_X8R8G8B8 = 5'd5;
  localparam logic [4:0] FMT_A8R8G8B8 = 5'd6;
  localparam logic [4:0] FMT_INDEX8   = 5'd9;
  localparam logic [4:0] FMT_A8       = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_FORMAT   = 2'd2;

  localparam int unsigned NUM_COMP = 4;

  // Per-format component layout: shift, mask and enable for each lane
  typedef struct packed {
    logic [NUM_COMP-1:0][4:0]  sh;
    logic [NUM_COMP-1:0][31:0] mk;
    logic [NUM_COMP-1:0]       en;
  } layout_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [31:0] key_low;
    logic [31:0] key_high;
    logic [4:0]  surface_format;
  } cfg_t;

  function automatic layout_t fmt_layout(input logic [4:0] fmt);
    layout_t l;
    l = '0;
    case (fmt)
      FMT_X4R4G4B4: begin
        l.sh = {5'd0, 5'd0, 5'd4, 5'd8};
        l.mk = {32'h0, 32'hF, 32'hF, 32'hF};
        l.en = 4'b0111;
      end
      FMT_A4R4G4B4: begin
        l.sh = {5'd0, 5'd4, 5'd8, 5'd12};
        l.mk = {32'hF, 32'hF, 32'hF, 32'hF};
        l.en = 4'b1111;
      end
      FMT_X1R5G5B5: begin
        l.sh = {5'd0, 5'd0, 5'd5, 5'd10};
        l.mk = {32'h0, 32'h1F, 32'h1F, 32'h1F};
        l.en = 4'b0111;
      end
      FMT_A1R5G5B5: begin
        l.sh = {5'd0, 5'd5, 5'd10, 5'd15};
        l.mk = {32'h1F, 32'h1F, 32'h1F, 32'h1};
        l.en = 4'b1111;
      end
      FMT_R5G6B5: begin
        l.sh = {5'd0, 5'd0, 5'd5, 5'd11};
        l.mk = {32'h0, 32'h1F, 32'h3F, 32'h1F};
        l.en = 4'b0111;
      end
      FMT_X8R8G8B8: begin
        l.sh = {5'd0, 5'd0, 5'd8, 5'd16};
        l.mk = {32'h0, 32'hFF, 32'hFF, 32'hFF};
        l.en = 4'b0111;
      end
      FMT_A8R8G8B8: begin
        l.sh = {5'd0, 5'd8, 5'd16, 5'd24};
        l.mk = {32'hFF, 32'hFF, 32'hFF, 32'hFF};
        l.en = 4'b1111;
      end
      FMT_INDEX8, FMT_A8: begin
        l.mk[0] = 32'hFF;
        l.en    = 4'b0001;
      end
      default: begin
        // whole word as one component
        l.mk[0] = 32'hFFFF_FFFF;
        l.en    = 4'b0001;
      end
    endcase
    return l;
  endfunction

endpackage

>>> src/ckrm_regs.sv
module ckrm_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output ckrm_pkg::cfg_t     cfg
);

  logic [31:0] key_low;
  logic [31:0] key_high;
  logic [4:0]  surface_format;

  // Register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low        <= '0;
      key_high       <= '0;
      surface_format <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ckrm_pkg::REG_KEY_LOW:  key_low        <= cfg_data;
        ckrm_pkg::REG_KEY_HIGH: key_high       <= cfg_data;
        ckrm_pkg::REG_FORMAT:   surface_format <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.key_low        = key_low;
  assign cfg.key_high       = key_high;
  assign cfg.surface_format = surface_format;

endmodule

>>> src/ckrm_cmp.sv
module ckrm_cmp (
  input  ckrm_pkg::cfg_t cfg,
  input  logic [31:0]    pixel,
  output logic           match
);

  ckrm_pkg::layout_t           lay;
  logic [ckrm_pkg::NUM_COMP-1:0] lane_ok;

  assign lay = ckrm_pkg::fmt_layout(cfg.surface_format);

  // Per-lane extract and inclusive range check
  always_comb begin
    for (int i = 0; i < ckrm_pkg::NUM_COMP; i++) begin
      logic [31:0] p;
      logic [31:0] lo;
      logic [31:0] hi;
      p  = (pixel        >> lay.sh[i]) & lay.mk[i];
      lo = (cfg.key_low  >> lay.sh[i]) & lay.mk[i];
      hi = (cfg.key_high >> lay.sh[i]) & lay.mk[i];
      lane_ok[i] = !lay.en[i] || ((p >= lo) && (p <= hi));
    end
  end

  assign match = &lane_ok;

endmodule

>>> src/color_key_range_match.sv
// Color-key range match.
// The done strobe follows start through the input register and then the result register.
// Throughput: one pixel word per cycle; busy is always low, the compare is a single pass.
// Results cannot be stalled; done is high for exactly one cycle, and key_match holds until the next result.
// Synchronous active-high reset clears the key registers, the format and the valid flags.
module color_key_range_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pixel_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        key_match
);

  ckrm_pkg::cfg_t cfg;
  logic           accept;
  logic           in_valid;
  logic [31:0]    in_pixel;
  logic           match_comb;
  logic           match_reg;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ckrm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pixel <= pixel_value;
    end
  end

  ckrm_cmp u_cmp (
    .cfg   (cfg),
    .pixel (in_pixel),
    .match (match_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      match_reg <= match_comb;
    end
  end

  assign key_match = match_reg;

`ifndef SYNTHESIS
  // every strobe traces back to an accepted word, through the input and result registers
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("done without an accepted word");

  // an accepted word always produces a strobe
  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted word lost");

  // nothing leaves the block right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("strobe right after reset");
`endif

endmodule
